FILE: sv/debug_breakpoint_slot_manager_unit_assert.svh
// Assertion macros for the breakpoint slot manager
`ifndef DEBUG_BREAKPOINT_SLOT_MANAGER_UNIT_ASSERT_SVH
`define DEBUG_BREAKPOINT_SLOT_MANAGER_UNIT_ASSERT_SVH

// property must hold at every clock edge outside reset
`define DBSM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// antecedent implies consequent in the same cycle
`define DBSM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define DBSM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/dbsm_pkg.sv
package dbsm_pkg;

  localparam int unsigned SlotCnt  = 4;
  localparam int unsigned SlotW    = 2;
  localparam int unsigned AddrW    = 64;
  localparam int unsigned CtrlW    = 32;

  localparam logic [CtrlW-1:0] CtrlReset = 32'h0000_0400;
  localparam logic [CtrlW-1:0] ForceOne  = 32'h0000_0700;
  localparam logic [CtrlW-1:0] ForceZero = 32'h0000_D000;

  typedef enum logic {
    CMD_SET   = 1'b0,
    CMD_CLEAR = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    STATUS_DONE    = 2'd0,
    STATUS_BAD_LEN = 2'd1,
    STATUS_NO_SLOT = 2'd2
  } status_e;

  localparam logic [1:0] KindExec  = 2'd0;
  localparam logic [1:0] KindWrite = 2'd1;
  localparam logic [1:0] KindRw    = 2'd2;

  localparam logic [1:0] TypeExec  = 2'b00;
  localparam logic [1:0] TypeWrite = 2'b01;
  localparam logic [1:0] TypeRw    = 2'b11;

  localparam logic [1:0] LenCode1 = 2'b00;
  localparam logic [1:0] LenCode2 = 2'b01;
  localparam logic [1:0] LenCode4 = 2'b11;
  localparam logic [1:0] LenCode8 = 2'b10;

  typedef struct packed {
    logic             cmd;
    logic [AddrW-1:0] address;
    logic [1:0]       access_kind;
    logic [3:0]       length_bytes;
    logic             oneshot;
  } req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [SlotW-1:0] slot_used;
    logic [CtrlW-1:0] control_word;
  } res_t;

  // state update from the slot logic
  typedef struct packed {
    logic [CtrlW-1:0] ctrl;
    logic             wr_en;
    logic [SlotW-1:0] wr_slot;
  } upd_t;

  function automatic logic [1:0] kind_code(input logic [1:0] kind);
    logic [1:0] t;
    case (kind)
      KindWrite: t = TypeWrite;
      KindRw:    t = TypeRw;
      default:   t = TypeExec;
    endcase
    return t;
  endfunction

  // returns {ok, code}
  function automatic logic [2:0] len_code(input logic [3:0] len);
    logic [2:0] r;
    case (len)
      4'd1:    r = {1'b1, LenCode1};
      4'd2:    r = {1'b1, LenCode2};
      4'd4:    r = {1'b1, LenCode4};
      4'd8:    r = {1'b1, LenCode8};
      default: r = 3'b000;
    endcase
    return r;
  endfunction

endpackage

FILE: sv/dbsm_if.sv
interface dbsm_in_if;
  import dbsm_pkg::*;

  logic             valid;
  logic             ready;
  logic             cmd;
  logic [AddrW-1:0] address;
  logic [1:0]       access_kind;
  logic [3:0]       length_bytes;
  logic             oneshot;

  modport source (output valid, cmd, address, access_kind, length_bytes, oneshot,
                  input ready);
  modport sink   (input valid, cmd, address, access_kind, length_bytes, oneshot,
                  output ready);
endinterface

interface dbsm_out_if;
  import dbsm_pkg::*;

  logic             valid;
  logic             ready;
  logic [1:0]       status;
  logic [SlotW-1:0] slot_used;
  logic [CtrlW-1:0] control_word;

  modport source (output valid, status, slot_used, control_word, input ready);
  modport sink   (input valid, status, slot_used, control_word, output ready);
endinterface

FILE: sv/dbsm_slot_pick.sv
module dbsm_slot_pick (
  input  dbsm_pkg::req_t                  req_i,
  input  logic [dbsm_pkg::AddrW-1:0]      slot_addr_i [dbsm_pkg::SlotCnt],
  input  logic [dbsm_pkg::SlotCnt-1:0]    slot_oneshot_i,
  input  logic [dbsm_pkg::CtrlW-1:0]      ctrl_i,
  output dbsm_pkg::upd_t                  upd_o,
  output dbsm_pkg::res_t                  res_o
);
  import dbsm_pkg::*;

  logic [SlotCnt-1:0] match;
  logic [SlotCnt-1:0] avail;
  logic [CtrlW-1:0]   clr_mask;
  logic [CtrlW-1:0]   ctrl_f;
  logic [CtrlW-1:0]   ctrl_set;
  logic [2:0]         len_r;
  logic [1:0]         tbits;
  logic               found;
  logic [SlotW-1:0]   pick;

  always_comb begin
    clr_mask = '0;
    for (int i = 0; i < SlotCnt; i++) begin
      match[i] = (slot_addr_i[i] == req_i.address);
      clr_mask[2*i+1] = match[i] & slot_oneshot_i[i];
    end
  end

  assign ctrl_f = (ctrl_i | ForceOne) & ~ForceZero;
  assign len_r  = len_code(req_i.length_bytes);
  assign tbits  = kind_code(req_i.access_kind);

  always_comb begin
    found = 1'b0;
    pick  = '0;
    for (int i = 0; i < SlotCnt; i++) begin
      avail[i] = !ctrl_f[2*i+1] || match[i];
      if (avail[i] && !found) begin
        found = 1'b1;
        pick  = SlotW'(i);
      end
    end
  end

  always_comb begin
    ctrl_set = ctrl_f;
    for (int i = 0; i < SlotCnt; i++) begin
      if (pick == SlotW'(i)) begin
        ctrl_set[16+4*i +: 4] = {len_r[1:0], tbits};
        ctrl_set[2*i+1]       = 1'b1;
      end
    end
  end

  always_comb begin
    upd_o.ctrl         = ctrl_i;
    upd_o.wr_en        = 1'b0;
    upd_o.wr_slot      = pick;
    res_o.status       = STATUS_DONE;
    res_o.slot_used    = '0;
    if (req_i.cmd == CMD_CLEAR) begin
      upd_o.ctrl = ctrl_i & ~clr_mask;
    end else if (!len_r[2]) begin
      res_o.status = STATUS_BAD_LEN;
    end else if (!found) begin
      upd_o.ctrl   = ctrl_f;
      res_o.status = STATUS_NO_SLOT;
    end else begin
      upd_o.ctrl      = ctrl_set;
      upd_o.wr_en     = 1'b1;
      res_o.slot_used = pick;
    end
    res_o.control_word = upd_o.ctrl;
  end

endmodule

FILE: sv/debug_breakpoint_slot_manager_unit.sv
// Channel | Dir | Payload
// in_i    | in  | cmd, address, access_kind, length_bytes, oneshot
// out_o   | out | status, slot_used, control_word
//
// One command per cycle while the output is not stalled.
// The command is registered, resolved against the slot registers in one pass,
// and the result is registered; slot state updates as the command moves on.
// Reset: control word 0x400, all slot addresses and one-shot marks zero.
// A stalled output holds the command register; input stalls only then.
`include "debug_breakpoint_slot_manager_unit_assert.svh"

module debug_breakpoint_slot_manager_unit (
  input  logic clk_i,
  input  logic rst_ni,
  dbsm_in_if.sink    in_i,
  dbsm_out_if.source out_o
);
  import dbsm_pkg::*;

  logic                s1_valid_q, s1_valid_d;
  req_t                s1_req_q;
  logic                out_valid_q, out_valid_d;
  res_t                res_q;
  logic [AddrW-1:0]    slot_addr_q [SlotCnt];
  logic [SlotCnt-1:0]  slot_oneshot_q;
  logic [CtrlW-1:0]    ctrl_q;
  upd_t                upd;
  res_t                res_d;
  logic                in_xfer, out_adv, s1_adv;

  assign out_adv   = !out_valid_q || out_o.ready;
  assign s1_adv    = s1_valid_q && out_adv;
  assign in_i.ready = !s1_valid_q || out_adv;
  assign in_xfer   = in_i.valid && in_i.ready;

  assign s1_valid_d  = in_xfer ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_q);
  assign out_valid_d = out_adv ? s1_valid_q : out_valid_q;

  dbsm_slot_pick u_pick (
    .req_i         (s1_req_q),
    .slot_addr_i   (slot_addr_q),
    .slot_oneshot_i(slot_oneshot_q),
    .ctrl_i        (ctrl_q),
    .upd_o         (upd),
    .res_o         (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q     <= 1'b0;
      out_valid_q    <= 1'b0;
      ctrl_q         <= CtrlReset;
      slot_oneshot_q <= '0;
      for (int i = 0; i < SlotCnt; i++) begin
        slot_addr_q[i] <= '0;
      end
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (s1_adv) begin
        ctrl_q <= upd.ctrl;
        if (upd.wr_en) begin
          slot_addr_q[upd.wr_slot]    <= s1_req_q.address;
          slot_oneshot_q[upd.wr_slot] <= s1_req_q.oneshot;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_req_q.cmd          <= in_i.cmd;
      s1_req_q.address      <= in_i.address;
      s1_req_q.access_kind  <= in_i.access_kind;
      s1_req_q.length_bytes <= in_i.length_bytes;
      s1_req_q.oneshot      <= in_i.oneshot;
    end
    if (s1_adv) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.status       = res_q.status;
  assign out_o.slot_used    = res_q.slot_used;
  assign out_o.control_word = res_q.control_word;

  `DBSM_ASSERT(a_forced_bits, ctrl_q[10] && !ctrl_q[12] && !ctrl_q[14] && !ctrl_q[15], "forced control bits lost")
  `DBSM_ASSERT_IMP(a_fail_no_slot, out_valid_q && (res_q.status != STATUS_DONE), res_q.slot_used == '0, "slot reported on failed command")
  `DBSM_ASSERT_NXT(a_stall_hold, s1_valid_q && !out_adv, s1_valid_q && $stable(ctrl_q), "command lost or state changed during stall")
  `DBSM_ASSERT_IMP(a_set_enables, s1_adv && upd.wr_en, upd.ctrl[2*upd.wr_slot+1], "set slot not enabled")

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps

module tb;
  import dbsm_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned RandItems  = 550;
  localparam int unsigned PoolSize   = 6;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  bit steady = 1'b0;
  int unsigned cycles = 0;
  logic [AddrW-1:0] addr_pool [PoolSize];

  dbsm_in_if  in_if ();
  dbsm_out_if out_if ();

  debug_breakpoint_slot_manager_unit DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  class bp_scoreboard;
    logic [AddrW-1:0] slot_addr [SlotCnt];
    logic             slot_once [SlotCnt];
    logic [CtrlW-1:0] ctrl;
    res_t             expected_q [$];
    int unsigned      errors;

    function void power_on();
      int i;
      for (i = 0; i < SlotCnt; i++) begin
        slot_addr[i] = '0;
        slot_once[i] = 1'b0;
      end
      ctrl = CtrlReset;
      expected_q.delete();
      errors = 0;
    endfunction

    function void note_command(req_t r);
      res_t       e;
      logic [1:0] tcode;
      logic [1:0] lcode;
      bit         len_ok;
      int         i;
      e.status = STATUS_DONE;
      e.slot_used = '0;
      if (r.cmd == CMD_CLEAR) begin
        for (i = 0; i < SlotCnt; i++) begin
          if (slot_addr[i] == r.address && slot_once[i]) ctrl[2*i+1] = 1'b0;
        end
      end else begin
        case (r.access_kind)
          KindWrite: tcode = TypeWrite;
          KindRw:    tcode = TypeRw;
          default:   tcode = TypeExec;
        endcase
        len_ok = 1'b1;
        case (r.length_bytes)
          4'd1: lcode = LenCode1;
          4'd2: lcode = LenCode2;
          4'd4: lcode = LenCode4;
          4'd8: lcode = LenCode8;
          default: begin
            lcode = LenCode1;
            len_ok = 1'b0;
          end
        endcase
        if (!len_ok) begin
          e.status = STATUS_BAD_LEN;
        end else begin
          ctrl = (ctrl | ForceOne) & ~ForceZero;
          e.status = STATUS_NO_SLOT;
          for (i = 0; i < SlotCnt && e.status == STATUS_NO_SLOT; i++) begin
            if (!ctrl[2*i+1] || slot_addr[i] == r.address) begin
              slot_addr[i] = r.address;
              slot_once[i] = r.oneshot;
              ctrl[16+4*i +: 4] = {lcode, tcode};
              ctrl[2*i+1] = 1'b1;
              e.status = STATUS_DONE;
              e.slot_used = i[SlotW-1:0];
            end
          end
        end
      end
      e.control_word = ctrl;
      expected_q.push_back(e);
    endfunction

    function void check_result(res_t got);
      res_t e;
      if (expected_q.size() == 0) begin
        $error("unexpected result: status %0d slot_used %0d control_word %h",
               got.status, got.slot_used, got.control_word);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (got.status !== e.status) begin
        $error("status: expected %0d, actual %0d", e.status, got.status);
        errors++;
      end
      if (got.slot_used !== e.slot_used) begin
        $error("slot_used: expected %0d, actual %0d", e.slot_used, got.slot_used);
        errors++;
      end
      if (got.control_word !== e.control_word) begin
        $error("control_word: expected %h, actual %h", e.control_word, got.control_word);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  bp_scoreboard sb;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  function automatic req_t make_cmd(logic c, logic [AddrW-1:0] a, logic [1:0] k,
                                    logic [3:0] len, logic once);
    req_t r;
    r.cmd = c;
    r.address = a;
    r.access_kind = k;
    r.length_bytes = len;
    r.oneshot = once;
    return r;
  endfunction

  function automatic req_t pick_command();
    req_t        r;
    int unsigned lens [4];
    lens = '{1, 2, 4, 8};
    r.cmd = ($urandom_range(99) < 25) ? CMD_CLEAR : CMD_SET;
    if ($urandom_range(99) < 80) r.address = addr_pool[3'($urandom_range(PoolSize-1))];
    else r.address = {$urandom, $urandom};
    r.access_kind = 2'($urandom_range(3));
    if ($urandom_range(99) < 85) r.length_bytes = 4'(lens[2'($urandom_range(3))]);
    else r.length_bytes = 4'($urandom_range(15));
    r.oneshot = ($urandom_range(99) < 70);
    return r;
  endfunction

  task automatic send_command(input req_t r);
    while (!steady && $urandom_range(99) < 37) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.cmd          <= r.cmd;
    in_if.address      <= r.address;
    in_if.access_kind  <= r.access_kind;
    in_if.length_bytes <= r.length_bytes;
    in_if.oneshot      <= r.oneshot;
    @(negedge clk_i);
    while (!in_if.ready) @(negedge clk_i);
    @(posedge clk_i);
    sb.note_command(r);
  endtask

  // result side: sample on the falling edge, check at the rising edge
  initial begin
    res_t got;
    bit   fire;
    out_if.ready <= 1'b0;
    forever begin
      @(negedge clk_i);
      fire = rst_ni && out_if.valid && out_if.ready;
      got.status = out_if.status;
      got.slot_used = out_if.slot_used;
      got.control_word = out_if.control_word;
      @(posedge clk_i);
      if (fire) sb.check_result(got);
      out_if.ready <= steady || ($urandom_range(99) >= 37);
    end
  end

  initial begin
    logic [AddrW-1:0] ones;
    int               n;
    ones = '1;
    sb = new();
    sb.power_on();
    in_if.valid        <= 1'b0;
    in_if.cmd          <= CMD_SET;
    in_if.address      <= '0;
    in_if.access_kind  <= KindExec;
    in_if.length_bytes <= 4'd0;
    in_if.oneshot      <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // fill all four slots, one per access kind and length
    send_command(make_cmd(CMD_SET, '0, KindExec, 4'd1, 1'b1));
    send_command(make_cmd(CMD_SET, ones, KindWrite, 4'd2, 1'b0));
    send_command(make_cmd(CMD_SET, 64'h1000, KindRw, 4'd4, 1'b1));
    send_command(make_cmd(CMD_SET, 64'h2000, 2'd3, 4'd8, 1'b1));
    // full
    send_command(make_cmd(CMD_SET, 64'h3000, KindExec, 4'd1, 1'b1));
    // same address reuses its slot
    send_command(make_cmd(CMD_SET, 64'h1000, KindWrite, 4'd8, 1'b0));
    // bad lengths
    send_command(make_cmd(CMD_SET, 64'h3000, KindRw, 4'd0, 1'b1));
    send_command(make_cmd(CMD_SET, 64'h3000, KindWrite, 4'd3, 1'b0));
    send_command(make_cmd(CMD_SET, ones, 2'd3, 4'd15, 1'b1));
    send_command(make_cmd(CMD_SET, 64'h0, KindExec, 4'd5, 1'b1));
    // clears: one-shot hit, non one-shot, one-shot hit
    send_command(make_cmd(CMD_CLEAR, '0, KindExec, 4'd0, 1'b0));
    send_command(make_cmd(CMD_CLEAR, ones, 2'd3, 4'd15, 1'b1));
    send_command(make_cmd(CMD_CLEAR, 64'h2000, KindRw, 4'd8, 1'b0));
    // clear of a disabled one-shot slot
    send_command(make_cmd(CMD_CLEAR, 64'h2000, KindExec, 4'd1, 1'b1));
    send_command(make_cmd(CMD_SET, 64'h4000, KindRw, 4'd2, 1'b1));
    send_command(make_cmd(CMD_CLEAR, 64'h1000, KindExec, 4'd1, 1'b1));
    send_command(make_cmd(CMD_CLEAR, 64'h4000, KindExec, 4'd1, 1'b0));
    // first disabled slot wins over a later matching address
    send_command(make_cmd(CMD_SET, 64'h1000, KindExec, 4'd4, 1'b1));
    send_command(make_cmd(CMD_CLEAR, 64'h1000, KindExec, 4'd1, 1'b0));
    send_command(make_cmd(CMD_SET, 64'h5555_AAAA_5555_AAAA, KindWrite, 4'd8, 1'b1));
    send_command(make_cmd(CMD_SET, 64'hAAAA_5555_AAAA_5555, KindRw, 4'd1, 1'b0));

    addr_pool[0] = '0;
    addr_pool[1] = ones;
    for (n = 2; n < PoolSize; n++) addr_pool[n] = {$urandom, $urandom};
    for (n = 0; n < RandItems; n++) begin
      steady = (n >= 250 && n < 370);
      if ($urandom_range(99) < 2) begin
        addr_pool[3'($urandom_range(PoolSize-1))] = {$urandom, $urandom};
      end
      send_command(pick_command());
    end
    steady = 1'b0;
    in_if.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
